@@ hw/rtl/minimum_covering_window_assert.svh @@
// ----------------------------------------------------------------------------
// minimum_covering_window assertion macros
// Property wrappers clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MINIMUM_COVERING_WINDOW_ASSERT_SVH
`define MINIMUM_COVERING_WINDOW_ASSERT_SVH

// same-cycle implication
`define MCW_CHECK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("minimum_covering_window check failed");

// next-cycle implication
`define MCW_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("minimum_covering_window check failed");

`endif

@@ hw/rtl/mcw_pkg.sv @@
// ----------------------------------------------------------------------------
// mcw_pkg
// Shared opcodes, field widths and arithmetic unit types.
// ----------------------------------------------------------------------------
package mcw_pkg;

    localparam int OPC_W     = 2;
    localparam int SYM_W     = 8;
    localparam int POS_OUT_W = 12;
    localparam int M_DATA_W  = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2,
        OP_END     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ALU_INC     = 2'b01,
        ALU_DEC_SAT = 2'b10
    } alu_op_t;

    typedef struct packed {
        logic le;
        logic ge;
    } alu_flags_t;

endpackage

@@ hw/rtl/mcw_alu.sv @@
// ----------------------------------------------------------------------------
// mcw_alu
// Shared count unit: increment or saturating decrement, compared to a bound.
// ----------------------------------------------------------------------------
module mcw_alu #(
    parameter int W = 13
) (
    input  mcw_pkg::alu_op_t    op,
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    output logic [W-1:0]        res,
    output mcw_pkg::alu_flags_t flags
);
    import mcw_pkg::*;

    always_comb begin
        case (op)
            ALU_INC: begin
                res = a + 1'b1;
            end
            ALU_DEC_SAT: begin
                res = (a != '0) ? a - 1'b1 : a;
            end
            default: begin
                res = a;
            end
        endcase
        flags.le = (res <= b);
        flags.ge = (res >= b);
    end

endmodule

@@ hw/rtl/mcw_count_table.sv @@
// ----------------------------------------------------------------------------
// mcw_count_table
// Per-symbol count RAM with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module mcw_count_table #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 9
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (clear) begin
                vld_reg <= '0;
            end else if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ hw/rtl/mcw_pos_queue.sv @@
// ----------------------------------------------------------------------------
// mcw_pos_queue
// Queue RAM of text positions and their symbols, with head and tail pointers.
// ----------------------------------------------------------------------------
module mcw_pos_queue #(
    parameter int DEPTH = 4096,
    parameter int SW    = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic                     push,
    input  logic [$clog2(DEPTH)-1:0] push_pos,
    input  logic [SW-1:0]            push_sym,
    input  logic                     pop,
    output logic [$clog2(DEPTH)-1:0] rd_pos,
    output logic [SW-1:0]            rd_sym,
    output logic                     empty,
    output logic                     full
);
    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [PW+SW-1:0] mem [DEPTH];
    logic [PW+SW-1:0] rd_data_reg;
    logic [CNTW-1:0]  head_reg;
    logic [CNTW-1:0]  head_next;
    logic [CNTW-1:0]  tail_reg;
    logic [CNTW-1:0]  tail_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg[PW-1:0]] <= {push_pos, push_sym};
        end
        if (pop) begin
            rd_data_reg <= mem[head_reg[PW-1:0]];
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (clear) begin
            head_next = '0;
            tail_next = '0;
        end else begin
            if (push) begin
                tail_next = tail_reg + 1'b1;
            end
            if (pop) begin
                head_next = head_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    assign rd_pos = rd_data_reg[PW+SW-1:SW];
    assign rd_sym = rd_data_reg[SW-1:0];
    assign empty  = (head_reg == tail_reg);
    assign full   = (tail_reg >= CNTW'(DEPTH));

endmodule

@@ hw/rtl/minimum_covering_window.sv @@
// ----------------------------------------------------------------------------
// minimum_covering_window
// Shortest text window holding every pattern byte with multiplicity.
// ----------------------------------------------------------------------------
//   channel | dir | tdata                      | tuser
//   s_      | in  | [7:0] symbol               | [1:0] opcode
//   m_      | out | found, start, end, overrun | -
//
// A text item that completes a cover pops queued positions through the
// pop, look and decrement states and then updates the best window; each
// queued position is popped at most once per job. The count RAMs and the
// queue RAM have registered reads and feed one shared count unit.
// aresetn clears control state and all count valid bits.
// s_tready is low while an item is in work, and an end item holds while
// an earlier result is not yet taken.
module minimum_covering_window #(
    parameter int ALPHABET_SIZE = 256,
    parameter int MAX_TEXT      = 4096,
    parameter int MAX_PATTERN   = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mcw_pkg::SYM_W-1:0]     s_tdata,   // [7:0] symbol
    input  logic [mcw_pkg::OPC_W-1:0]     s_tuser,   // [1:0] opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mcw_pkg::M_DATA_W-1:0]  m_tdata    // found, window_start,
                                                     // window_end, overrun
);
    import mcw_pkg::*;

    localparam int AIW = $clog2(ALPHABET_SIZE);
    localparam int PW  = $clog2(MAX_TEXT);
    localparam int TPW = $clog2(MAX_TEXT + 1);
    localparam int RCW = $clog2(MAX_PATTERN + 1);
    localparam int CW  = (RCW > TPW) ? RCW : TPW;
    localparam int PADW = M_DATA_W - 2 - 2 * POS_OUT_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PAT  = 8'b0000_0010,
        S_TXT  = 8'b0000_0100,
        S_POP  = 8'b0000_1000,
        S_LOOK = 8'b0001_0000,
        S_DEC  = 8'b0010_0000,
        S_BEST = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [AIW-1:0]        sym_reg, sym_next;
    logic [AIW-1:0]        kb_reg, kb_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [PW-1:0]         k_reg, k_next;
    logic [TPW-1:0]        text_pos_reg, text_pos_next;
    logic [RCW-1:0]        pat_len_reg, pat_len_next;
    logic [RCW-1:0]        covered_reg, covered_next;
    logic [PW-1:0]         best_start_reg, best_start_next;
    logic [PW-1:0]         best_end_reg, best_end_next;
    logic                  best_valid_reg, best_valid_next;
    logic                  overrun_reg, overrun_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    opcode_t               opc;
    logic [AIW-1:0]        sym_idx;
    logic                  sym_oob;
    logic                  load_out;
    logic [RCW-1:0]        cov_inc;

    logic                  tbl_clear;
    logic                  tbl_rd_en;
    logic [AIW-1:0]        tbl_rd_addr;
    logic [AIW-1:0]        tbl_wr_addr;
    logic                  req_wr_en;
    logic                  win_wr_en;
    logic [RCW-1:0]        req_rd_data;
    logic [TPW-1:0]        win_rd_data;

    logic                  q_clear;
    logic                  q_push;
    logic                  q_pop;
    logic [PW-1:0]         q_rd_pos;
    logic [AIW-1:0]        q_rd_sym;
    logic                  q_empty;
    logic                  q_full;

    alu_op_t               alu_op;
    logic [CW-1:0]         alu_a;
    logic [CW-1:0]         alu_b;
    logic [CW-1:0]         alu_res;
    alu_flags_t            alu_flags;

    assign opc      = opcode_t'(s_tuser);
    assign sym_idx  = s_tdata[AIW-1:0];
    assign sym_oob  = ({1'b0, s_tdata} >= (SYM_W + 1)'(ALPHABET_SIZE));
    assign s_tready = (state_reg == S_IDLE);
    assign cov_inc  = covered_reg + RCW'(alu_flags.le);

    mcw_count_table #(
        .DEPTH (ALPHABET_SIZE),
        .WIDTH (RCW)
    ) u_req_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (tbl_clear),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (req_rd_data),
        .wr_en   (req_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (alu_res[RCW-1:0])
    );

    mcw_count_table #(
        .DEPTH (ALPHABET_SIZE),
        .WIDTH (TPW)
    ) u_win_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (tbl_clear),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (win_rd_data),
        .wr_en   (win_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (alu_res[TPW-1:0])
    );

    mcw_pos_queue #(
        .DEPTH (MAX_TEXT),
        .SW    (AIW)
    ) u_pos_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (q_clear),
        .push     (q_push),
        .push_pos (pos_reg),
        .push_sym (sym_reg),
        .pop      (q_pop),
        .rd_pos   (q_rd_pos),
        .rd_sym   (q_rd_sym),
        .empty    (q_empty),
        .full     (q_full)
    );

    mcw_alu #(
        .W (CW)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    always_comb begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        kb_next         = kb_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        text_pos_next   = text_pos_reg;
        pat_len_next    = pat_len_reg;
        covered_next    = covered_reg;
        best_start_next = best_start_reg;
        best_end_next   = best_end_reg;
        best_valid_next = best_valid_reg;
        overrun_next    = overrun_reg;
        load_out        = 1'b0;
        tbl_clear       = 1'b0;
        tbl_rd_en       = 1'b0;
        tbl_rd_addr     = (state_reg == S_LOOK) ? q_rd_sym : sym_idx;
        tbl_wr_addr     = (state_reg == S_DEC) ? kb_reg : sym_reg;
        req_wr_en       = 1'b0;
        win_wr_en       = 1'b0;
        q_clear         = 1'b0;
        q_push          = 1'b0;
        q_pop           = 1'b0;
        alu_op          = ALU_INC;
        alu_a           = CW'(win_rd_data);
        alu_b           = CW'(req_rd_data);

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (opc)
                        OP_CLEAR: begin
                            tbl_clear       = 1'b1;
                            q_clear         = 1'b1;
                            text_pos_next   = '0;
                            pat_len_next    = '0;
                            covered_next    = '0;
                            best_start_next = '0;
                            best_end_next   = '0;
                            best_valid_next = 1'b0;
                            overrun_next    = 1'b0;
                        end
                        OP_PATTERN: begin
                            if (text_pos_reg == '0) begin
                                if (pat_len_reg >= RCW'(MAX_PATTERN) || sym_oob) begin
                                    overrun_next = 1'b1;
                                end else begin
                                    tbl_rd_en  = 1'b1;
                                    sym_next   = sym_idx;
                                    state_next = S_PAT;
                                end
                            end
                        end
                        OP_TEXT: begin
                            if (text_pos_reg >= TPW'(MAX_TEXT)) begin
                                overrun_next = 1'b1;
                            end else begin
                                text_pos_next = text_pos_reg + 1'b1;
                                pos_next      = text_pos_reg[PW-1:0];
                                if (!sym_oob) begin
                                    tbl_rd_en  = 1'b1;
                                    sym_next   = sym_idx;
                                    state_next = S_TXT;
                                end
                            end
                        end
                        OP_END: begin
                            if (!m_valid_reg || m_tready) begin
                                load_out = 1'b1;
                            end else begin
                                state_next = S_EMIT;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PAT: begin
                alu_op       = ALU_INC;
                alu_a        = CW'(req_rd_data);
                req_wr_en    = 1'b1;
                pat_len_next = pat_len_reg + 1'b1;
                state_next   = S_IDLE;
            end
            S_TXT: begin
                if (req_rd_data == '0) begin
                    state_next = S_IDLE;
                end else if (q_full) begin
                    overrun_next = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    q_push       = 1'b1;
                    alu_op       = ALU_INC;
                    win_wr_en    = 1'b1;
                    covered_next = cov_inc;
                    k_next       = '0;
                    state_next   = (cov_inc == pat_len_reg) ? S_POP : S_IDLE;
                end
            end
            S_POP: begin
                if (q_empty) begin
                    state_next = S_BEST;
                end else begin
                    q_pop      = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                k_next     = q_rd_pos;
                kb_next    = q_rd_sym;
                tbl_rd_en  = 1'b1;
                state_next = S_DEC;
            end
            S_DEC: begin
                alu_op     = ALU_DEC_SAT;
                win_wr_en  = 1'b1;
                state_next = alu_flags.ge ? S_POP : S_BEST;
            end
            S_BEST: begin
                if (!best_valid_reg ||
                    (best_end_reg - best_start_reg) > (pos_reg - k_reg)) begin
                    best_start_next = k_reg;
                    best_end_next   = pos_reg;
                    best_valid_next = 1'b1;
                end
                if (covered_reg != '0) begin
                    covered_next = covered_reg - 1'b1;
                end
                state_next = S_IDLE;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {PADW'(0), overrun_reg,
                            POS_OUT_W'(best_end_reg),
                            POS_OUT_W'(best_start_reg),
                            best_valid_reg};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            text_pos_reg   <= '0;
            pat_len_reg    <= '0;
            covered_reg    <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
            best_valid_reg <= 1'b0;
            overrun_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            text_pos_reg   <= text_pos_next;
            pat_len_reg    <= pat_len_next;
            covered_reg    <= covered_next;
            best_start_reg <= best_start_next;
            best_end_reg   <= best_end_next;
            best_valid_reg <= best_valid_next;
            overrun_reg    <= overrun_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg    <= sym_next;
        kb_reg     <= kb_next;
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ hw/rtl/mcw_checker.sv @@
// ----------------------------------------------------------------------------
// mcw_checker
// Port-level checks on minimum_covering_window, bound to the top level.
// ----------------------------------------------------------------------------
`include "minimum_covering_window_assert.svh"

module mcw_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [mcw_pkg::OPC_W-1:0]    s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mcw_pkg::M_DATA_W-1:0] m_tdata
);
    import mcw_pkg::*;

    logic end_acc;

    assign end_acc = s_tvalid && s_tready && (s_tuser == OP_END);

    `MCW_CHECK_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MCW_CHECK_SAME(a_result_from_end, $rose(m_tvalid), $past(end_acc))
    `MCW_CHECK_NEXT(a_end_gives_result, end_acc, m_tvalid)
    `MCW_CHECK_SAME(a_miss_is_zero, m_tvalid && !m_tdata[0], m_tdata[24:1] == '0)

endmodule

bind minimum_covering_window mcw_checker u_mcw_checker (.*);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// minimum_covering_window testbench
// Sends clear, pattern, text and end items over the input stream. A
// scoreboard predicts the shortest covering window of each job and checks
// each result item field by field against the oldest prediction. Directed
// jobs cover empty patterns, extreme bytes, ties, late pattern bytes and
// pattern overflow. Random jobs follow, mostly well formed, with
// random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import mcw_pkg::*;

    class window_scoreboard;
        localparam int ALPHA_SIZE  = 256;
        localparam int TEXT_LIMIT  = 4096;
        localparam int PAT_LIMIT   = 256;

        int unsigned need_count [ALPHA_SIZE];
        int unsigned have_count [ALPHA_SIZE];
        int unsigned pos_fifo [TEXT_LIMIT];
        logic [7:0]  text_mem [TEXT_LIMIT];
        int unsigned fifo_head, fifo_tail, covered, pat_len, text_len;
        int unsigned best_lo, best_hi;
        bit          best_ok, overflow;
        logic [25:0] window_q [$];
        int          errors, checked, results_due;

        function new();
            errors = 0;
            checked = 0;
            results_due = 0;
            clear_job();
        endfunction

        function void clear_job();
            for (int i = 0; i < ALPHA_SIZE; i++) begin
                need_count[i] = 0;
                have_count[i] = 0;
            end
            fifo_head = 0;
            fifo_tail = 0;
            covered = 0;
            pat_len = 0;
            text_len = 0;
            best_lo = 0;
            best_hi = 0;
            best_ok = 0;
            overflow = 0;
        endfunction

        function void add_pattern(logic [7:0] sym);
            if (text_len != 0) return;
            if (pat_len >= PAT_LIMIT || int'(sym) >= ALPHA_SIZE) begin
                overflow = 1;
                return;
            end
            need_count[sym]++;
            pat_len++;
        endfunction

        function void add_text(logic [7:0] sym);
            int unsigned pos;
            int unsigned k;
            logic [7:0]  kb;
            pos = text_len;
            k = 0;
            if (pos >= TEXT_LIMIT) begin
                overflow = 1;
                return;
            end
            text_mem[pos] = sym;
            text_len = pos + 1;
            if (int'(sym) >= ALPHA_SIZE || need_count[sym] == 0) return;
            if (fifo_tail >= TEXT_LIMIT) begin
                overflow = 1;
                return;
            end
            pos_fifo[fifo_tail] = pos;
            fifo_tail++;
            have_count[sym]++;
            if (have_count[sym] <= need_count[sym]) covered++;
            if (covered != pat_len) return;
            while (fifo_head < fifo_tail) begin
                k = pos_fifo[fifo_head];
                fifo_head++;
                kb = text_mem[k];
                if (have_count[kb] != 0) have_count[kb]--;
                if (need_count[kb] > have_count[kb]) break;
            end
            if (!best_ok || (best_hi - best_lo) > (pos - k)) begin
                best_lo = k;
                best_hi = pos;
                best_ok = 1;
            end
            if (covered != 0) covered--;
        endfunction

        function void note_item(opcode_t op, logic [7:0] sym);
            logic [11:0] lo, hi;
            case (op)
                OP_CLEAR:   clear_job();
                OP_PATTERN: add_pattern(sym);
                OP_TEXT:    add_text(sym);
                default: begin
                    lo = best_ok ? best_lo[11:0] : 12'd0;
                    hi = best_ok ? best_hi[11:0] : 12'd0;
                    window_q.push_back({overflow, hi, lo, best_ok});
                    results_due++;
                end
            endcase
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        endtask

        task check_result(logic [31:0] data);
            logic [25:0] want;
            checked++;
            if (window_q.size() == 0) begin
                report("result with none pending, found", data[0], 0);
                return;
            end
            want = window_q.pop_front();
            if (data[0] !== want[0])         report("found", data[0], want[0]);
            if (data[12:1] !== want[12:1])   report("window_start", data[12:1], want[12:1]);
            if (data[24:13] !== want[24:13]) report("window_end", data[24:13], want[24:13]);
            if (data[25] !== want[25])       report("overrun", data[25], want[25]);
        endtask

        function int pending();
            return window_q.size();
        endfunction
    endclass

    localparam int IDLE_LIMIT = 60000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    window_scoreboard board;
    bit          calm;
    int          sent_items;
    int          job_count;
    int          idle_cycles;
    int          stall_left;

    minimum_covering_window #(
        .ALPHABET_SIZE(window_scoreboard::ALPHA_SIZE),
        .MAX_TEXT(window_scoreboard::TEXT_LIMIT),
        .MAX_PATTERN(window_scoreboard::PAT_LIMIT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
        end
    end

    task automatic send_item(opcode_t op, logic [7:0] sym);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 2'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= sym;
        do @(posedge aclk); while (!s_tready);
        board.note_item(op, sym);
        sent_items++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_item(OP_END, 8'h00);
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_END, 8'hA5);
        send_item(OP_TEXT, 8'h61);
        send_item(OP_END, 8'h00);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_PATTERN, 8'h00);
        send_item(OP_PATTERN, 8'hFF);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_END, 8'hFF);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_PATTERN, 8'h55);
        send_item(OP_PATTERN, 8'h55);
        send_item(OP_PATTERN, 8'hAA);
        send_item(OP_TEXT, 8'h55);
        send_item(OP_TEXT, 8'hAA);
        send_item(OP_TEXT, 8'h13);
        send_item(OP_TEXT, 8'h55);
        send_item(OP_TEXT, 8'h55);
        send_item(OP_TEXT, 8'hAA);
        send_item(OP_END, 8'h00);
        send_item(OP_PATTERN, 8'hAA);
        send_item(OP_TEXT, 8'hAA);
        send_item(OP_END, 8'h00);
    endtask

    task automatic run_overflow_jobs();
        send_item(OP_CLEAR, 8'h00);
        for (int i = 0; i < 258; i++) send_item(OP_PATTERN, 8'(i + 1));
        send_item(OP_TEXT, 8'h01);
        send_item(OP_TEXT, 8'h02);
        send_item(OP_END, 8'h00);
    endtask

    task automatic run_job();
        logic [7:0] letters [6];
        int nlet, plen, tlen, style, r;
        opcode_t op;
        style = $urandom_range(0, 99);
        nlet = $urandom_range(1, 6);
        for (int i = 0; i < 6; i++) letters[i] = 8'($urandom);
        if (style < 80) begin
            send_item(OP_CLEAR, 8'($urandom));
            plen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
            for (int i = 0; i < plen; i++) send_item(OP_PATTERN, letters[$urandom_range(0, nlet - 1)]);
            tlen = $urandom_range(0, 24);
            for (int i = 0; i < tlen; i++) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_item(OP_TEXT, 8'($urandom));
                end else begin
                    send_item(OP_TEXT, letters[$urandom_range(0, nlet - 1)]);
                end
                if ($urandom_range(0, 99) < 5) send_item(OP_END, 8'($urandom));
            end
        end else if (style < 92) begin
            if ($urandom_range(0, 1) == 0) send_item(OP_CLEAR, 8'($urandom));
            tlen = $urandom_range(3, 16);
            for (int i = 0; i < tlen; i++) begin
                r = $urandom_range(0, 99);
                op = (r < 35) ? OP_PATTERN : (r < 85) ? OP_TEXT : (r < 95) ? OP_END : OP_CLEAR;
                send_item(op, letters[$urandom_range(0, nlet - 1)]);
            end
        end else begin
            tlen = $urandom_range(2, 12);
            for (int i = 0; i < tlen; i++) send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom));
        end
        send_item(OP_END, 8'($urandom));
    endtask

    initial begin
        board = new();
        calm = 1'b0;
        sent_items = 0;
        job_count = 0;
        idle_cycles = 0;
        stall_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = OP_CLEAR;
        m_tready = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        drain();
        calm = 1'b1;
        run_overflow_jobs();
        calm = 1'b0;

        while (sent_items < 800) begin
            if ($urandom_range(0, 9) == 0) calm = ~calm;
            run_job();
            job_count++;
            if (job_count == 20) drain();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain();
        repeat (100) @(posedge aclk);
        if (board.pending() != 0) board.report("results still pending", board.pending(), 0);

        $display("%0d input items: directed, pattern overflow and %0d random jobs",
                 sent_items, job_count);
        $display("%0d result items checked, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ minimum_covering_window.f @@
+incdir+hw/rtl
hw/rtl/mcw_pkg.sv
hw/rtl/mcw_alu.sv
hw/rtl/mcw_count_table.sv
hw/rtl/mcw_pos_queue.sv
hw/rtl/minimum_covering_window.sv
hw/rtl/mcw_checker.sv
verif/testbench.sv
